// File: hdl/text_window_line_assembler_unit_assert.svh
// Assertion macros for the text window line assembler.
`ifndef TEXT_WINDOW_LINE_ASSEMBLER_UNIT_ASSERT_SVH
`define TEXT_WINDOW_LINE_ASSEMBLER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define TWLA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define TWLA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define TWLA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TWLA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hdl/twla_pkg.sv
`default_nettype none

package twla_pkg;

   localparam int WINDOW_COUNT = 4;
   localparam int LINE_COLS    = 32;
   localparam int WINDOW_ROWS  = 24;

   localparam int WIN_W  = 2;
   localparam int COL_W  = 5;   // column index within a line
   localparam int CUR_W  = 6;   // cursor, fill end up to LINE_COLS
   localparam int ROW_W  = 5;
   localparam int CHAR_W = 8;
   localparam int ADDR_W = WIN_W + COL_W;
   localparam int MEM_DEPTH = WINDOW_COUNT * LINE_COLS;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;

   localparam logic [CUR_W-1:0] LINE_END = CUR_W'(LINE_COLS);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_COLS - 1);
   localparam logic [ROW_W-1:0] ROWS_MAX = ROW_W'(WINDOW_ROWS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(WINDOW_ROWS - 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_FILL = 3'b010,
      S_EMIT = 3'b100
   } state_type;

endpackage

`default_nettype wire

// File: hdl/text_window_line_assembler_unit.sv
// An accepted character writes 1 to 32 columns of the line memory, one column a cycle
// (up to 32 for a newline); a completed line then streams out as 32 transfers at one a
// cycle while rsp_tready holds, each read registered into the output register first.
// A new character is taken only in idle, after the fill and any line output of the
// last one; there is one memory write port. Reset is synchronous: cursors and row
// counts clear at once, the line memory is not cleared and needs no clearing pass.
`default_nettype none

`include "text_window_line_assembler_unit_assert.svh"

module text_window_line_assembler_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // window [1:0], char_code [9:2], zeros above
   input  wire logic [twla_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // out_window [1:0], screen_row [6:2], column [11:7], glyph [19:12], zeros above
   output logic [twla_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // scroll_first [0]
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast
);

   twla_pkg::state_type state_ff, state_in;

   logic [twla_pkg::CUR_W-1:0] cursor_ff [twla_pkg::WINDOW_COUNT];
   logic [twla_pkg::CUR_W-1:0] cursor_in [twla_pkg::WINDOW_COUNT];
   logic [twla_pkg::ROW_W-1:0] row_cnt_ff [twla_pkg::WINDOW_COUNT];
   logic [twla_pkg::ROW_W-1:0] row_cnt_in [twla_pkg::WINDOW_COUNT];

   logic [twla_pkg::WIN_W-1:0]  win_ff, win_in;
   logic [twla_pkg::CUR_W-1:0]  fill_col_ff, fill_col_in;
   logic [twla_pkg::CUR_W-1:0]  fill_end_ff, fill_end_in;
   logic [twla_pkg::CHAR_W-1:0] fill_char_ff, fill_char_in;
   logic                        emit_ff, emit_in;
   logic [twla_pkg::ROW_W-1:0]  row_ff, row_in;
   logic                        scroll_ff, scroll_in;
   logic [twla_pkg::COL_W-1:0]  emit_col_ff, emit_col_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Line memory and its registered read side.
   logic [twla_pkg::CHAR_W-1:0] line_mem [twla_pkg::MEM_DEPTH];
   logic [twla_pkg::CHAR_W-1:0] glyph_ff;
   logic [twla_pkg::WIN_W-1:0]  out_win_ff;
   logic [twla_pkg::ROW_W-1:0]  out_row_ff;
   logic [twla_pkg::COL_W-1:0]  out_col_ff;
   logic                        out_scroll_ff;
   logic                        out_last_ff;

   logic                        mem_we;
   logic                        rd_en;
   logic [twla_pkg::WIN_W-1:0]  req_window;
   logic [twla_pkg::CHAR_W-1:0] req_char;
   logic [twla_pkg::CUR_W-1:0]  cur_col;
   logic [twla_pkg::CUR_W-1:0]  fill_next;
   logic [twla_pkg::ROW_W-1:0]  cur_rows;

   assign req_window = req_tdata[twla_pkg::WIN_W-1:0];
   assign req_char   = req_tdata[twla_pkg::WIN_W +: twla_pkg::CHAR_W];
   assign req_tready = (state_ff == twla_pkg::S_IDLE);
   assign cur_col    = cursor_ff[req_window];
   assign fill_next  = fill_col_ff + twla_pkg::CUR_W'(1);
   assign cur_rows   = row_cnt_ff[win_ff];

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      row_cnt_in   = row_cnt_ff;
      win_in       = win_ff;
      fill_col_in  = fill_col_ff;
      fill_end_in  = fill_end_ff;
      fill_char_in = fill_char_ff;
      emit_in      = emit_ff;
      row_in       = row_ff;
      scroll_in    = scroll_ff;
      emit_col_in  = emit_col_ff;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      unique case (state_ff)
         twla_pkg::S_IDLE: begin
            if (req_tvalid) begin
               win_in      = req_window;
               fill_col_in = cur_col;
               case (req_char)
                  twla_pkg::CODE_TAB: begin
                     // Next multiple of four; the cursor is below the line end here.
                     fill_end_in  = {cur_col[twla_pkg::CUR_W-1:2] + 4'd1, 2'b00};
                     fill_char_in = twla_pkg::CODE_SPACE;
                  end
                  twla_pkg::CODE_NEWLINE: begin
                     fill_end_in  = twla_pkg::LINE_END;
                     fill_char_in = twla_pkg::CODE_SPACE;
                  end
                  default: begin
                     fill_end_in  = cur_col + twla_pkg::CUR_W'(1);
                     fill_char_in = req_char;
                  end
               endcase
               emit_in  = (fill_end_in == twla_pkg::LINE_END);
               state_in = twla_pkg::S_FILL;
            end
         end
         twla_pkg::S_FILL: begin
            mem_we      = 1'b1;
            fill_col_in = fill_next;
            if (fill_next == fill_end_ff) begin
               if (emit_ff) begin
                  cursor_in[win_ff] = '0;
                  if (cur_rows >= twla_pkg::ROWS_MAX) begin
                     scroll_in = 1'b1;
                     row_in    = twla_pkg::LAST_ROW;
                     row_cnt_in[win_ff] = twla_pkg::ROWS_MAX;
                  end else begin
                     scroll_in = 1'b0;
                     row_in    = cur_rows;
                     row_cnt_in[win_ff] = cur_rows + twla_pkg::ROW_W'(1);
                  end
                  emit_col_in = '0;
                  state_in    = twla_pkg::S_EMIT;
               end else begin
                  cursor_in[win_ff] = fill_end_ff;
                  state_in          = twla_pkg::S_IDLE;
               end
            end
         end
         twla_pkg::S_EMIT: begin
            // A read may be issued whenever the output register is free next cycle.
            rd_en = ~rsp_valid_ff | rsp_tready;
            if (rd_en) begin
               rsp_valid_in = 1'b1;
               emit_col_in  = emit_col_ff + twla_pkg::COL_W'(1);
               if (emit_col_ff == twla_pkg::LAST_COL) begin
                  state_in = twla_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = twla_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= twla_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < twla_pkg::WINDOW_COUNT; i++) begin
            cursor_ff[i]  <= '0;
            row_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cursor_ff    <= cursor_in;
         row_cnt_ff   <= row_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff       <= win_in;
      fill_col_ff  <= fill_col_in;
      fill_end_ff  <= fill_end_in;
      fill_char_ff <= fill_char_in;
      emit_ff      <= emit_in;
      row_ff       <= row_in;
      scroll_ff    <= scroll_in;
      emit_col_ff  <= emit_col_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[{win_ff, fill_col_ff[twla_pkg::COL_W-1:0]}] <= fill_char_ff;
      end
      if (rd_en) begin
         glyph_ff      <= line_mem[{win_ff, emit_col_ff}];
         out_win_ff    <= win_ff;
         out_row_ff    <= row_ff;
         out_col_ff    <= emit_col_ff;
         out_scroll_ff <= scroll_ff & (emit_col_ff == '0);
         out_last_ff   <= (emit_col_ff == twla_pkg::LAST_COL);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, glyph_ff, out_col_ff, out_row_ff, out_win_ff};
   assign rsp_tuser  = out_scroll_ff;
   assign rsp_tlast  = out_last_ff;

   `TWLA_ASSERT_IMP(a_fill_in_range, clock, reset,
      state_ff == twla_pkg::S_FILL,
      (fill_col_ff < fill_end_ff) && (fill_end_ff <= twla_pkg::LINE_END))
   `TWLA_ASSERT_IMP(a_scroll_on_first, clock, reset,
      rsp_valid_ff && out_scroll_ff,
      (out_col_ff == '0) && (out_row_ff == twla_pkg::LAST_ROW))
   `TWLA_ASSERT_NEXT(a_accept_fills, clock, reset,
      req_tvalid && req_tready, state_ff == twla_pkg::S_FILL)
   `TWLA_ASSERT_IMP(a_emit_output_busy, clock, reset,
      state_ff == twla_pkg::S_EMIT && emit_col_ff != '0, rsp_valid_ff)

endmodule

`default_nettype wire
